@@ hdl/msm_pkg.sv @@
`default_nettype none
package msm_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 48;

  localparam logic [CFG_IW-1:0] REG_ROT_COS    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ROT_SIN    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SHIFT_X    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SHIFT_Y    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_METRIC = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RADIUS_SQ  = 3'd5;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_LOAD_SEG = 2'd1;
  localparam logic [1:0] CMD_LOAD_PT  = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // Segment parameter divider: 16 quotient bits, divisor |ab|^2 below 2^51.
  localparam int U_STEPS = 16;
  localparam int U_DIV_W = 51;
  // Metric divider: 49 quotient bits, divisor k below 2^49.
  localparam int Q_STEPS = 49;
  localparam int Q_DIV_W = 49;

  localparam logic [47:0] METRIC_SAT = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] first_x;
    logic signed [23:0] first_y;
    logic signed [23:0] second_x;
    logic signed [23:0] second_y;
  } in_t;

  typedef struct packed {
    logic               found;
    logic               from_segment;
    logic signed [23:0] moved_x;
    logic signed [23:0] moved_y;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
    logic [47:0]        best_metric;
  } out_t;

  // Data riding along the segment parameter divider.
  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [25:0] abx;
    logic signed [25:0] aby;
    logic               uz;
    logic               uo;
    logic               seg;
  } usd_t;

  // Data riding along the metric divider.
  typedef struct packed {
    logic [48:0]        d2;
    logic signed [23:0] rx;
    logic signed [23:0] ry;
    logic               seg;
    logic               zk;
    logic               big;
  } qsd_t;

endpackage
`default_nettype wire

@@ hdl/msm_ram.sv @@
`default_nettype none
module msm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/msm_div_cell.sv @@
`default_nettype none
// One restoring division step: shift in the next dividend bit, subtract the
// divisor if it fits, and hand everything to the next cell.
module msm_div_cell #(
  parameter int DIV_W  = 49,
  parameter int LOW_W  = 49,
  parameter int Q_W    = 49,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [DIV_W:0]    in_rem,
  input  wire logic [DIV_W-1:0]  in_div,
  input  wire logic [LOW_W-1:0]  in_low,
  input  wire logic [Q_W-1:0]    in_q,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic      [DIV_W:0]    out_rem,
  output logic      [DIV_W-1:0]  out_div,
  output logic      [LOW_W-1:0]  out_low,
  output logic      [Q_W-1:0]    out_q,
  output logic      [SIDE_W-1:0] out_side
);

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] div_ext;
  logic           ge;

  assign shifted = {in_rem[DIV_W-1:0], in_low[LOW_W-1]};
  assign div_ext = {1'b0, in_div};
  assign ge      = shifted >= div_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= ge ? shifted - div_ext : shifted;
    out_div  <= in_div;
    out_low  <= {in_low[LOW_W-2:0], 1'b0};
    out_q    <= {in_q[Q_W-2:0], ge};
    out_side <= in_side;
  end

endmodule
`default_nettype wire

@@ hdl/metric_segment_match_search_unit.sv @@
`default_nettype none
// Clear, load segment and load point give no result. A query strobes its
// result after the segment scan has drained when a segment matches, and
// after the point scan has drained as well otherwise.
// Candidates enter a 76-stage pipeline one a cycle; results cannot stall.
// Reset zeroes both counts and loads the register defaults; stores keep data.
module metric_segment_match_search_unit #(
  parameter int MAX_SEGMENTS = 256,
  parameter int MAX_POINTS   = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire msm_pkg::in_t                  in_data,
  output logic                               busy,
  output logic                               out_valid,
  output msm_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [msm_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [msm_pkg::CFG_DW-1:0]    cfg_wdata
);
  import msm_pkg::*;

  localparam int SAW = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PAW = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int IW  = SCW > PCW ? SCW : PCW;
  localparam int USW = $bits(usd_t);
  localparam int QSW = $bits(qsd_t);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MV1  = 3'd1;
  localparam logic [2:0] ST_MV2  = 3'd2;
  localparam logic [2:0] ST_SEG  = 3'd3;
  localparam logic [2:0] ST_SDRN = 3'd4;
  localparam logic [2:0] ST_PT   = 3'd5;
  localparam logic [2:0] ST_PDRN = 3'd6;

  // Configuration.
  logic signed [17:0] rot_cos_r, rot_sin_r;
  logic signed [23:0] shift_x_r, shift_y_r;
  logic [47:0]        max_r, radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r <= 18'sd65536;
      rot_sin_r <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
      max_r     <= 48'd4294967296;
      radius_r  <= 48'd38654705664;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_COS:    rot_cos_r <= cfg_wdata[17:0];
        REG_ROT_SIN:    rot_sin_r <= cfg_wdata[17:0];
        REG_SHIFT_X:    shift_x_r <= cfg_wdata[23:0];
        REG_SHIFT_Y:    shift_y_r <= cfg_wdata[23:0];
        REG_MAX_METRIC: max_r     <= cfg_wdata;
        REG_RADIUS_SQ:  radius_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control.
  logic [2:0]     state_r;
  logic [SCW-1:0] seg_cnt_r;
  logic [PCW-1:0] pt_cnt_r;
  logic [IW-1:0]  idx_r;
  logic           accept;
  logic           pipe_busy;
  logic           issue;
  logic           v0_r, v0_seg_r;

  assign accept = start && !busy;
  assign busy   = state_r != ST_IDLE;
  assign issue  = (state_r == ST_SEG && idx_r < IW'(seg_cnt_r)) ||
                  (state_r == ST_PT && idx_r < IW'(pt_cnt_r));

  logic seg_we, pt_we;
  assign seg_we = accept && in_data.command == CMD_LOAD_SEG &&
                  seg_cnt_r < SCW'(MAX_SEGMENTS);
  assign pt_we  = accept && in_data.command == CMD_LOAD_PT &&
                  pt_cnt_r < PCW'(MAX_POINTS);

  logic [47:0] seg_a_rd, seg_b_rd, pt_rd;

  msm_ram #(.WIDTH(48), .DEPTH(MAX_SEGMENTS)) u_seg_start (
    .clk(clk), .we(seg_we), .waddr(seg_cnt_r[SAW-1:0]),
    .wdata({in_data.first_x, in_data.first_y}),
    .raddr(idx_r[SAW-1:0]), .rdata(seg_a_rd)
  );

  msm_ram #(.WIDTH(48), .DEPTH(MAX_SEGMENTS)) u_seg_end (
    .clk(clk), .we(seg_we), .waddr(seg_cnt_r[SAW-1:0]),
    .wdata({in_data.second_x, in_data.second_y}),
    .raddr(idx_r[SAW-1:0]), .rdata(seg_b_rd)
  );

  msm_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(pt_cnt_r[PAW-1:0]),
    .wdata({in_data.first_x, in_data.first_y}),
    .raddr(idx_r[PAW-1:0]), .rdata(pt_rd)
  );

  // Query transform.
  logic signed [23:0] qx_r, qy_r, mx_r, my_r;
  logic signed [41:0] p_cx_r, p_sy_r, p_sx_r, p_cy_r;
  logic signed [42:0] t_x, t_y;
  logic signed [27:0] m_x, m_y;

  assign t_x = 43'(p_cx_r) - 43'(p_sy_r);
  assign t_y = 43'(p_sx_r) + 43'(p_cy_r);
  assign m_x = 28'(t_x >>> 16) + 28'(shift_x_r);
  assign m_y = 28'(t_y >>> 16) + 28'(shift_y_r);

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  // Best candidate.
  logic [47:0]        best_r;
  logic               found_r, fromseg_r;
  logic signed [23:0] bx_r, by_r;
  logic               q_out_v;
  logic [47:0]        cand_m;
  qsd_t               q_side_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      seg_cnt_r  <= '0;
      pt_cnt_r   <= '0;
      idx_r      <= '0;
      v0_r       <= 1'b0;
      out_valid  <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      v0_r      <= issue;
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (q_out_v && cand_m < best_r) begin
        found_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.command)
              CMD_CLEAR: begin
                seg_cnt_r <= '0;
                pt_cnt_r  <= '0;
              end
              CMD_LOAD_SEG: if (seg_we) seg_cnt_r <= seg_cnt_r + 1'b1;
              CMD_LOAD_PT:  if (pt_we) pt_cnt_r <= pt_cnt_r + 1'b1;
              default: begin
                found_r <= 1'b0;
                idx_r   <= '0;
                state_r <= ST_MV1;
              end
            endcase
          end
        end
        ST_MV1: state_r <= ST_MV2;
        ST_MV2: state_r <= ST_SEG;
        ST_SEG: if (!issue) state_r <= ST_SDRN;
        ST_SDRN: begin
          if (!pipe_busy) begin
            if (found_r) begin
              out_valid <= 1'b1;
              state_r   <= ST_IDLE;
            end else begin
              idx_r   <= '0;
              state_r <= ST_PT;
            end
          end
        end
        ST_PT: if (!issue) state_r <= ST_PDRN;
        ST_PDRN: begin
          if (!pipe_busy) begin
            out_valid <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    v0_seg_r <= state_r == ST_SEG;
    if (accept) begin
      qx_r      <= in_data.first_x;
      qy_r      <= in_data.first_y;
      best_r    <= max_r;
      fromseg_r <= 1'b0;
      bx_r      <= '0;
      by_r      <= '0;
    end else if (q_out_v && cand_m < best_r) begin
      best_r    <= cand_m;
      fromseg_r <= q_side_out.seg;
      bx_r      <= q_side_out.rx;
      by_r      <= q_side_out.ry;
    end
    p_cx_r <= rot_cos_r * qx_r;
    p_sy_r <= rot_sin_r * qy_r;
    p_sx_r <= rot_sin_r * qx_r;
    p_cy_r <= rot_cos_r * qy_r;
    if (state_r == ST_MV2) begin
      mx_r <= sat24(m_x);
      my_r <= sat24(m_y);
    end
  end

  assign out_data.found        = found_r;
  assign out_data.from_segment = fromseg_r;
  assign out_data.moved_x      = mx_r;
  assign out_data.moved_y      = my_r;
  assign out_data.ref_x        = bx_r;
  assign out_data.ref_y        = by_r;
  assign out_data.best_metric  = best_r;

  // Front stages: a point is a segment whose ends coincide.
  logic signed [23:0] a_x, a_y, b_x, b_y;
  assign a_x = v0_seg_r ? seg_a_rd[47:24] : pt_rd[47:24];
  assign a_y = v0_seg_r ? seg_a_rd[23:0] : pt_rd[23:0];
  assign b_x = v0_seg_r ? seg_b_rd[47:24] : pt_rd[47:24];
  assign b_y = v0_seg_r ? seg_b_rd[23:0] : pt_rd[23:0];

  logic               v1_r, v2_r, v3_r;
  logic               s1_seg, s2_seg;
  logic signed [23:0] s1_ax, s1_ay, s2_ax, s2_ay;
  logic signed [25:0] s1_abx, s1_aby, s2_abx, s2_aby;
  logic signed [24:0] s1_pax, s1_pay;
  logic signed [51:0] s2_xx, s2_yy;
  logic signed [50:0] s2_dx, s2_dy;
  logic [U_DIV_W-1:0] s3_den;
  logic [U_DIV_W:0]   s3_rem;
  usd_t               s3_side;
  logic [U_DIV_W:0]   den_w;
  logic signed [51:0] dot_w;

  assign den_w = 52'(s2_xx) + 52'(s2_yy);
  assign dot_w = 52'(s2_dx) + 52'(s2_dy);

  always_ff @(posedge clk) begin
    s1_ax  <= a_x;
    s1_ay  <= a_y;
    s1_abx <= 26'(b_x) - 26'(a_x);
    s1_aby <= 26'(b_y) - 26'(a_y);
    s1_pax <= 25'(mx_r) - 25'(a_x);
    s1_pay <= 25'(my_r) - 25'(a_y);
    s1_seg <= v0_seg_r;

    s2_ax  <= s1_ax;
    s2_ay  <= s1_ay;
    s2_abx <= s1_abx;
    s2_aby <= s1_aby;
    s2_seg <= s1_seg;
    s2_xx  <= s1_abx * s1_abx;
    s2_yy  <= s1_aby * s1_aby;
    s2_dx  <= 51'(s1_pax * s1_abx);
    s2_dy  <= 51'(s1_pay * s1_aby);

    s3_den      <= den_w[U_DIV_W-1:0];
    s3_rem      <= dot_w[U_DIV_W:0];
    s3_side.ax  <= s2_ax;
    s3_side.ay  <= s2_ay;
    s3_side.abx <= s2_abx;
    s3_side.aby <= s2_aby;
    s3_side.seg <= s2_seg;
    s3_side.uz  <= dot_w <= 52'sd0;
    s3_side.uo  <= dot_w > 52'sd0 && dot_w[U_DIV_W:0] >= den_w;
  end

  // Segment parameter divider chain.
  logic [U_STEPS:0]                 u_v;
  logic [U_STEPS:0][U_DIV_W:0]      u_rem;
  logic [U_STEPS:0][U_DIV_W-1:0]    u_div;
  logic [U_STEPS:0][U_STEPS-1:0]    u_low;
  logic [U_STEPS:0][U_STEPS-1:0]    u_q;
  logic [U_STEPS:0][USW-1:0]        u_side;

  assign u_v[0]    = v3_r;
  assign u_rem[0]  = s3_rem;
  assign u_div[0]  = s3_den;
  assign u_low[0]  = '0;
  assign u_q[0]    = '0;
  assign u_side[0] = s3_side;

  for (genvar g = 0; g < U_STEPS; g++) begin : g_ucell
    msm_div_cell #(.DIV_W(U_DIV_W), .LOW_W(U_STEPS), .Q_W(U_STEPS), .SIDE_W(USW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(u_v[g]), .in_rem(u_rem[g]), .in_div(u_div[g]),
      .in_low(u_low[g]), .in_q(u_q[g]), .in_side(u_side[g]),
      .out_valid(u_v[g+1]), .out_rem(u_rem[g+1]), .out_div(u_div[g+1]),
      .out_low(u_low[g+1]), .out_q(u_q[g+1]), .out_side(u_side[g+1])
    );
  end

  // Closest point, then the metric terms.
  usd_t               u_o;
  logic [16:0]        u_par;
  assign u_o   = u_side[U_STEPS];
  assign u_par = u_o.uo ? 17'd65536 : (u_o.uz ? 17'd0 : {1'b0, u_q[U_STEPS]});

  logic               v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic signed [23:0] s4_ax, s4_ay;
  logic signed [43:0] s4_px, s4_py;
  logic               s4_seg, s5_seg, s6_seg, s7_seg, s8_seg, s9_seg, s10_seg;
  logic signed [23:0] s5_rx, s5_ry, s6_rx, s6_ry, s7_rx, s7_ry;
  logic signed [23:0] s8_rx, s8_ry, s9_rx, s9_ry, s10_rx, s10_ry;
  logic signed [24:0] s5_dx, s5_dy;
  logic signed [49:0] s6_ddx, s6_ddy;
  logic signed [47:0] s6_rrx, s6_rry;
  logic signed [48:0] s6_c1, s6_c2;
  logic [48:0]        s7_d2, s7_k, s8_d2, s8_k, s9_d2, s9_k, s10_d2, s10_k;
  logic [47:0]        s7_mag;
  logic               s7_zk, s8_zk, s9_zk, s10_zk;
  logic [15:0]        s8_hi;
  logic [31:0]        s8_lo;
  logic [63:0]        s8_ll, s9_ll;
  logic [47:0]        s9_hl;
  logic [31:0]        s9_hh;
  logic [95:0]        s10_sq;
  logic signed [26:0] rx_w, ry_w;
  logic signed [48:0] cross_w;

  assign rx_w    = 27'(s4_ax) + 27'(s4_px >>> 16);
  assign ry_w    = 27'(s4_ay) + 27'(s4_py >>> 16);
  assign cross_w = s6_c1 - s6_c2;

  always_ff @(posedge clk) begin
    s4_ax  <= u_o.ax;
    s4_ay  <= u_o.ay;
    s4_seg <= u_o.seg;
    s4_px  <= $signed({1'b0, u_par}) * u_o.abx;
    s4_py  <= $signed({1'b0, u_par}) * u_o.aby;

    s5_rx  <= rx_w[23:0];
    s5_ry  <= ry_w[23:0];
    s5_dx  <= 25'(mx_r) - 25'(rx_w);
    s5_dy  <= 25'(my_r) - 25'(ry_w);
    s5_seg <= s4_seg;

    s6_ddx <= s5_dx * s5_dx;
    s6_ddy <= s5_dy * s5_dy;
    s6_rrx <= s5_rx * s5_rx;
    s6_rry <= s5_ry * s5_ry;
    s6_c1  <= s5_dx * s5_ry;
    s6_c2  <= s5_dy * s5_rx;
    s6_rx  <= s5_rx;
    s6_ry  <= s5_ry;
    s6_seg <= s5_seg;

    s7_d2  <= 49'(s6_ddx) + 49'(s6_ddy);
    s7_k   <= 49'(s6_rrx) + 49'(s6_rry) + 49'(radius_r);
    s7_zk  <= (49'(s6_rrx) + 49'(s6_rry) + 49'(radius_r)) == 49'd0;
    s7_mag <= cross_w[48] ? 48'(-cross_w) : cross_w[47:0];
    s7_rx  <= s6_rx;
    s7_ry  <= s6_ry;
    s7_seg <= s6_seg;

    // The cross term is squared via partial products of its 16/32-bit parts.
    s8_hi  <= s7_mag[47:32];
    s8_lo  <= s7_mag[31:0];
    s8_ll  <= s7_mag[31:0] * s7_mag[31:0];
    s8_d2  <= s7_d2;
    s8_k   <= s7_k;
    s8_zk  <= s7_zk;
    s8_rx  <= s7_rx;
    s8_ry  <= s7_ry;
    s8_seg <= s7_seg;

    s9_hl  <= s8_hi * s8_lo;
    s9_hh  <= s8_hi * s8_hi;
    s9_ll  <= s8_ll;
    s9_d2  <= s8_d2;
    s9_k   <= s8_k;
    s9_zk  <= s8_zk;
    s9_rx  <= s8_rx;
    s9_ry  <= s8_ry;
    s9_seg <= s8_seg;

    s10_sq  <= {s9_hh, 64'd0} + {15'd0, s9_hl, 33'd0} + {32'd0, s9_ll};
    s10_d2  <= s9_d2;
    s10_k   <= s9_k;
    s10_zk  <= s9_zk;
    s10_rx  <= s9_rx;
    s10_ry  <= s9_ry;
    s10_seg <= s9_seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else begin
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= u_v[U_STEPS];
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  // Metric divider chain. When the top bits of the dividend already reach a
  // nonzero k, the quotient exceeds any squared distance; the metric is zero.
  logic [46:0] sq_top;
  logic        big_w;
  qsd_t        q_side_in;

  assign sq_top = s10_sq[95:49];
  assign big_w  = {2'b00, sq_top} >= s10_k;

  always_comb begin
    q_side_in.d2  = s10_d2;
    q_side_in.rx  = s10_rx;
    q_side_in.ry  = s10_ry;
    q_side_in.seg = s10_seg;
    q_side_in.zk  = s10_zk;
    q_side_in.big = big_w;
  end

  logic [Q_STEPS:0]                 q_v;
  logic [Q_STEPS:0][Q_DIV_W:0]      q_rem;
  logic [Q_STEPS:0][Q_DIV_W-1:0]    q_div;
  logic [Q_STEPS:0][Q_STEPS-1:0]    q_low;
  logic [Q_STEPS:0][Q_STEPS-1:0]    q_q;
  logic [Q_STEPS:0][QSW-1:0]        q_side;

  assign q_v[0]    = v10_r;
  assign q_rem[0]  = big_w ? '0 : {3'b000, sq_top};
  assign q_div[0]  = s10_k;
  assign q_low[0]  = s10_sq[48:0];
  assign q_q[0]    = '0;
  assign q_side[0] = q_side_in;

  for (genvar g = 0; g < Q_STEPS; g++) begin : g_qcell
    msm_div_cell #(.DIV_W(Q_DIV_W), .LOW_W(Q_STEPS), .Q_W(Q_STEPS), .SIDE_W(QSW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(q_v[g]), .in_rem(q_rem[g]), .in_div(q_div[g]),
      .in_low(q_low[g]), .in_q(q_q[g]), .in_side(q_side[g]),
      .out_valid(q_v[g+1]), .out_rem(q_rem[g+1]), .out_div(q_div[g+1]),
      .out_low(q_low[g+1]), .out_q(q_q[g+1]), .out_side(q_side[g+1])
    );
  end

  logic [48:0] m_raw;
  assign q_out_v    = q_v[Q_STEPS];
  assign q_side_out = q_side[Q_STEPS];

  always_comb begin
    if (q_side_out.zk) begin
      m_raw = q_side_out.d2;
    end else if (q_side_out.big || q_side_out.d2 <= q_q[Q_STEPS]) begin
      m_raw = '0;
    end else begin
      m_raw = q_side_out.d2 - q_q[Q_STEPS];
    end
  end
  assign cand_m = m_raw[48] ? METRIC_SAT : m_raw[47:0];

  assign pipe_busy = v0_r | v1_r | v2_r | v3_r | (|u_v) | v4_r | v5_r | v6_r |
                     v7_r | v8_r | v9_r | v10_r | (|q_v);

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while a command is still running");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pipe_busy)
    else $error("candidates in flight while idle");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.ref_x == 24'sd0 && out_data.ref_y == 24'sd0 && !out_data.from_segment)
    else $error("reference reported without a match");

  // The point scan only starts when no segment matched.
  a_seg_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PT && idx_r == '0 |-> !found_r)
    else $error("point scan started after a segment matched");

endmodule
`default_nettype wire

@@ dv/msm_checker.sv @@
`timescale 1ns / 1ps
module msm_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  msm_pkg::in_t                 in_data,
  input  logic                         out_valid,
  input  msm_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [msm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [msm_pkg::CFG_DW-1:0]   cfg_wdata,
  output int                           fail_count,
  output int                           pending,
  output int                           query_count,
  output int                           segment_hits,
  output int                           point_hits
);
  import msm_pkg::*;

  localparam int DEPTH = 256;
  localparam longint SAT48 = 64'h0000_FFFF_FFFF_FFFF;

  // Mirror of the pose and search settings.
  longint pose_cos, pose_sin, pose_dx, pose_dy;
  longint accept_limit, radius_sq;

  longint seg_ax [DEPTH];
  longint seg_ay [DEPTH];
  longint seg_bx [DEPTH];
  longint seg_by [DEPTH];
  longint pt_x [DEPTH];
  longint pt_y [DEPTH];
  int     seg_count, pt_count;

  out_t match_queue[$];

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Squared metric distance of the moved point to a reference point.
  function automatic longint score(input longint dx, input longint dy,
                                   input longint rx, input longint ry);
    longint d2, k, cr, mag, m;
    logic [127:0] prod, quot;
    d2 = dx * dx + dy * dy;
    k = rx * rx + ry * ry + radius_sq;
    if (k == 0) begin
      m = d2;
    end else begin
      cr = dx * ry - dy * rx;
      mag = (cr < 0) ? -cr : cr;
      prod = 128'(mag) * 128'(mag);
      quot = prod / 128'(k);
      m = (128'(d2) > quot) ? d2 - longint'(quot[63:0]) : 0;
    end
    return (m > SAT48) ? SAT48 : m;
  endfunction

  function automatic void nearest_on_segment(input longint px, input longint py,
                                             input int idx,
                                             output longint rx, output longint ry);
    longint abx, aby, den, dot, u;
    logic [127:0] num;
    abx = seg_bx[idx] - seg_ax[idx];
    aby = seg_by[idx] - seg_ay[idx];
    den = abx * abx + aby * aby;
    if (den == 0) begin
      rx = seg_ax[idx];
      ry = seg_ay[idx];
      return;
    end
    dot = (px - seg_ax[idx]) * abx + (py - seg_ay[idx]) * aby;
    if (dot <= 0) begin
      u = 0;
    end else if (dot >= den) begin
      u = 65536;
    end else begin
      num = 128'(dot) << 16;
      num = num / 128'(den);
      u = longint'(num[63:0]);
    end
    rx = seg_ax[idx] + ((u * abx) >>> 16);
    ry = seg_ay[idx] + ((u * aby) >>> 16);
  endfunction

  function automatic out_t search_match(input longint qx, input longint qy);
    out_t   r;
    longint mx, my, rx, ry, d, best, bx, by;
    logic   hit, seg_hit;
    mx = clamp24(((pose_cos * qx - pose_sin * qy) >>> 16) + pose_dx);
    my = clamp24(((pose_sin * qx + pose_cos * qy) >>> 16) + pose_dy);
    best = accept_limit;
    bx = 0;
    by = 0;
    hit = 1'b0;
    seg_hit = 1'b0;
    for (int i = 0; i < seg_count; i++) begin
      nearest_on_segment(mx, my, i, rx, ry);
      d = score(mx - rx, my - ry, rx, ry);
      if (d < best) begin
        best = d; bx = rx; by = ry; hit = 1'b1; seg_hit = 1'b1;
      end
    end
    if (!hit) begin
      for (int i = 0; i < pt_count; i++) begin
        d = score(mx - pt_x[i], my - pt_y[i], pt_x[i], pt_y[i]);
        if (d < best) begin
          best = d; bx = pt_x[i]; by = pt_y[i]; hit = 1'b1;
        end
      end
    end
    r.found = hit;
    r.from_segment = seg_hit;
    r.moved_x = mx[23:0];
    r.moved_y = my[23:0];
    r.ref_x = bx[23:0];
    r.ref_y = by[23:0];
    r.best_metric = best[47:0];
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] want,
                        input logic [63:0] got);
    $display("MISMATCH at %0t, %s: expected %0h, got %0h", $time, field, want, got);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    query_count = 0;
    segment_hits = 0;
    point_hits = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      pose_cos = 65536;
      pose_sin = 0;
      pose_dx = 0;
      pose_dy = 0;
      accept_limit = 64'd4294967296;
      radius_sq = 64'd38654705664;
      seg_count = 0;
      pt_count = 0;
    end else begin
      // Compare first: a result cannot come from a transfer of this same edge.
      if (out_valid) begin
        if (match_queue.size() == 0) begin
          report("unexpected result", 64'd0, 64'(out_data.best_metric));
        end else begin
          want = match_queue.pop_front();
          if (out_data.found !== want.found)
            report("found", 64'(want.found), 64'(out_data.found));
          if (out_data.from_segment !== want.from_segment)
            report("from_segment", 64'(want.from_segment), 64'(out_data.from_segment));
          if (out_data.moved_x !== want.moved_x)
            report("moved_x", 64'(want.moved_x), 64'(out_data.moved_x));
          if (out_data.moved_y !== want.moved_y)
            report("moved_y", 64'(want.moved_y), 64'(out_data.moved_y));
          if (out_data.ref_x !== want.ref_x)
            report("ref_x", 64'(want.ref_x), 64'(out_data.ref_x));
          if (out_data.ref_y !== want.ref_y)
            report("ref_y", 64'(want.ref_y), 64'(out_data.ref_y));
          if (out_data.best_metric !== want.best_metric)
            report("best_metric", 64'(want.best_metric), 64'(out_data.best_metric));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROT_COS:    pose_cos = longint'($signed(cfg_wdata[17:0]));
          REG_ROT_SIN:    pose_sin = longint'($signed(cfg_wdata[17:0]));
          REG_SHIFT_X:    pose_dx = longint'($signed(cfg_wdata[23:0]));
          REG_SHIFT_Y:    pose_dy = longint'($signed(cfg_wdata[23:0]));
          REG_MAX_METRIC: accept_limit = longint'({16'd0, cfg_wdata});
          REG_RADIUS_SQ:  radius_sq = longint'({16'd0, cfg_wdata});
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_data.command)
          CMD_CLEAR: begin
            seg_count = 0;
            pt_count = 0;
          end
          CMD_LOAD_SEG: begin
            if (seg_count < DEPTH) begin
              seg_ax[seg_count] = longint'(in_data.first_x);
              seg_ay[seg_count] = longint'(in_data.first_y);
              seg_bx[seg_count] = longint'(in_data.second_x);
              seg_by[seg_count] = longint'(in_data.second_y);
              seg_count++;
            end
          end
          CMD_LOAD_PT: begin
            if (pt_count < DEPTH) begin
              pt_x[pt_count] = longint'(in_data.first_x);
              pt_y[pt_count] = longint'(in_data.first_y);
              pt_count++;
            end
          end
          default: begin
            want = search_match(longint'(in_data.first_x), longint'(in_data.first_y));
            match_queue = {match_queue, want};
            query_count++;
            if (want.found && want.from_segment) segment_hits++;
            else if (want.found) point_hits++;
          end
        endcase
      end
    end
    pending = match_queue.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import msm_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int TARGET_ITEMS = 900;

  logic              clk;
  logic              rst_n;
  logic              start;
  in_t               in_data;
  logic              busy;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  int fail_count, pending, query_count, segment_hits, point_hits;
  int item_count;
  int idle_cycles;
  bit no_gaps;
  longint base_x, base_y;

  metric_segment_match_search_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  msm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending(pending), .query_count(query_count), .segment_hits(segment_hits),
    .point_hits(point_hits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Any cycle with a transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] cmd, input longint fx, input longint fy,
                      input longint sx, input longint sy);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(7);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data.command <= cmd;
    in_data.first_x <= fx[23:0];
    in_data.first_y <= fy[23:0];
    in_data.second_x <= sx[23:0];
    in_data.second_y <= sy[23:0];
    do @(posedge clk); while (busy);
    item_count++;
  endtask

  // Holds off until every query has answered and the block is idle again.
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input longint value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[47:0];
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic longint near(input longint c, input int spread);
    return c + longint'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic longint any24();
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic longint any48();
    return longint'({$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF);
  endfunction

  task automatic set_pose(input int phase);
    drain();
    case (phase % 5)
      0: begin
        write_reg(REG_ROT_COS, 65536);
        write_reg(REG_ROT_SIN, 0);
        write_reg(REG_SHIFT_X, 0);
        write_reg(REG_SHIFT_Y, 0);
        write_reg(REG_MAX_METRIC, 64'd4294967296);
        write_reg(REG_RADIUS_SQ, 64'd38654705664);
      end
      1: begin
        write_reg(REG_ROT_COS, -65536);
        write_reg(REG_ROT_SIN, 65536);
        write_reg(REG_SHIFT_X, 8388607);
        write_reg(REG_SHIFT_Y, -8388608);
        write_reg(REG_MAX_METRIC, 64'h0000_FFFF_FFFF_FFFF);
        write_reg(REG_RADIUS_SQ, 64'h0000_FFFF_FFFF_FFFF);
      end
      2: begin
        write_reg(REG_ROT_COS, longint'($urandom_range(131072)) - 65536);
        write_reg(REG_ROT_SIN, longint'($urandom_range(131072)) - 65536);
        write_reg(REG_SHIFT_X, near(0, 65536));
        write_reg(REG_SHIFT_Y, near(0, 65536));
        write_reg(REG_MAX_METRIC, any48());
        write_reg(REG_RADIUS_SQ, any48());
      end
      3: begin
        write_reg(REG_ROT_COS, 65536);
        write_reg(REG_ROT_SIN, 0);
        write_reg(REG_SHIFT_X, any24());
        write_reg(REG_SHIFT_Y, any24());
        write_reg(REG_MAX_METRIC, 0);
        write_reg(REG_RADIUS_SQ, 0);
      end
      default: begin
        write_reg(REG_ROT_COS, 0);
        write_reg(REG_ROT_SIN, -65536);
        write_reg(REG_SHIFT_X, near(0, 4096));
        write_reg(REG_SHIFT_Y, near(0, 4096));
        write_reg(REG_MAX_METRIC, 64'd17179869184);
        write_reg(REG_RADIUS_SQ, longint'($urandom_range(65535)) << 20);
      end
    endcase
  endtask

  initial begin
    int scene, nseg, npt, nq;
    longint ax, ay;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    item_count = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty stores, field extremes, degenerate and repeated segments.
    send(CMD_QUERY, 0, 0, 0, 0);
    send(CMD_LOAD_PT, 65536, -65536, 0, 0);
    send(CMD_QUERY, 60000, -60000, 0, 0);
    send(CMD_LOAD_SEG, -8388608, -8388608, 8388607, 8388607);
    send(CMD_LOAD_SEG, 65536, 0, 65536, 0);
    send(CMD_LOAD_SEG, 65536, 0, 65536, 0);
    send(CMD_QUERY, 70000, 3000, 0, 0);
    send(CMD_QUERY, 8388607, 8388607, -8388608, -8388608);
    send(CMD_QUERY, -8388608, -8388608, 8388607, 8388607);
    send(CMD_LOAD_PT, 8388607, -8388608, -1, -1);
    send(CMD_QUERY, 8388607, -8388608, 0, 0);
    send(CMD_CLEAR, -1, -1, -1, -1);
    send(CMD_QUERY, 1000, 1000, 0, 0);
    // Zero radius with a reference at the origin leaves k at zero.
    drain();
    write_reg(REG_RADIUS_SQ, 0);
    send(CMD_LOAD_PT, 0, 0, 0, 0);
    send(CMD_QUERY, 100, -50, 0, 0);
    send(CMD_LOAD_SEG, 0, 0, 0, 0);
    send(CMD_QUERY, -300, 200, 0, 0);
    send(CMD_CLEAR, 0, 0, 0, 0);

    scene = 0;
    while (item_count < TARGET_ITEMS) begin
      if (scene % 10 == 0) set_pose(scene / 10);
      no_gaps = ($urandom_range(3) == 0);
      base_x = near(0, 1 << 20);
      base_y = near(0, 1 << 20);
      if (scene == 15) begin
        // Fill both stores past capacity; the extra loads must be dropped.
        send(CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 260; i++) begin
          ax = near(base_x, 1 << 19);
          ay = near(base_y, 1 << 19);
          send(CMD_LOAD_SEG, ax, ay, near(ax, 1 << 16), near(ay, 1 << 16));
        end
        for (int i = 0; i < 260; i++)
          send(CMD_LOAD_PT, near(base_x, 1 << 19), near(base_y, 1 << 19), 0, 0);
        for (int i = 0; i < 3; i++)
          send(CMD_QUERY, near(base_x, 1 << 19), near(base_y, 1 << 19), 0, 0);
      end else begin
        if ($urandom_range(4) != 0) send(CMD_CLEAR, any24(), any24(), any24(), any24());
        nseg = $urandom_range(5);
        npt = $urandom_range(5);
        nq = 1 + $urandom_range(4);
        for (int i = 0; i < nseg; i++) begin
          ax = near(base_x, 1 << 17);
          ay = near(base_y, 1 << 17);
          if ($urandom_range(7) == 0)
            send(CMD_LOAD_SEG, ax, ay, ax, ay);
          else
            send(CMD_LOAD_SEG, ax, ay, near(ax, 1 << 17), near(ay, 1 << 17));
        end
        for (int i = 0; i < npt; i++)
          send(CMD_LOAD_PT, near(base_x, 1 << 17), near(base_y, 1 << 17), any24(), any24());
        for (int i = 0; i < nq; i++)
          send(CMD_QUERY, near(base_x, 1 << 17), near(base_y, 1 << 17), any24(), any24());
        if ($urandom_range(9) == 0)
          send(2'($urandom_range(3)), any24(), any24(), any24(), any24());
      end
      scene++;
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d items over %0d scenes, including store overflow and all pose phases.",
             item_count, scene);
    $display("Checked %0d queries: %0d segment matches, %0d point matches, %0d misses.",
             query_count, segment_hits, point_hits,
             query_count - segment_hits - point_hits);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
